/* hdl/hgs_pkg.sv */
// ----------------------------------------------------------------------------
// hgs_pkg
// Shared types and constants for the heightfield gradient and slope block.
// ----------------------------------------------------------------------------
`default_nettype none

package hgs_pkg;

  // Largest row length held in the row stores
  localparam int HGS_MAX_WIDTH = 2048;

  // Configuration port address width (three 32-bit registers)
  localparam int HGS_PADDR_W = 4;

  // Register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH  = 2'd1;
  localparam logic [1:0] REG_INV_SPACING = 2'd2;

  // Reset values of the registers
  localparam logic [11:0] GRID_WIDTH_RST  = 12'd256;
  localparam logic [15:0] GRID_DEPTH_RST  = 16'd256;
  localparam logic [23:0] INV_SPACING_RST = 24'd65536;

  // Input command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] height;
  } hgs_in_t;

  typedef struct packed {
    logic signed [31:0] gradient_x;
    logic signed [31:0] gradient_z;
    logic [30:0]        slope;
    logic [10:0]        column;
    logic [15:0]        row;
    logic               last_of_grid;
  } hgs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_WR,
    ST_DIFF,
    ST_MUL,
    ST_RND,
    ST_SQR,
    ST_SUM,
    ST_SQRT,
    ST_DONE,
    ST_OUT
  } hgs_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd1;
    logic wr;
    logic diff;
    logic mul;
    logic rnd;
    logic sqr;
    logic sum;
    logic step;
    logic done;
  } hgs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic drop;
    logic emit;
    logic sqrt_last;
  } hgs_sts_t;

endpackage

`default_nettype wire

/* hdl/hgs_ram.sv */
// ----------------------------------------------------------------------------
// hgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/hgs_ctrl.sv */
// ----------------------------------------------------------------------------
// hgs_ctrl
// Sequencer: steps one transaction through store access, scaling and root.
// ----------------------------------------------------------------------------
`default_nettype none

module hgs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire hgs_pkg::hgs_sts_t sts,
  output hgs_pkg::hgs_cmd_t      cmd
);
  import hgs_pkg::*;

  hgs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RD0;
      ST_RD0:  state_nxt = sts.drop ? ST_IDLE : ST_RD1;
      ST_RD1:  state_nxt = ST_WR;
      ST_WR:   state_nxt = sts.emit ? ST_DIFF : ST_IDLE;
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_SQRT;
      ST_SQRT: if (sts.sqrt_last) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_RD1:  cmd.rd1  = 1'b1;
      ST_WR:   cmd.wr   = 1'b1;
      ST_DIFF: cmd.diff = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_RND:  cmd.rnd  = 1'b1;
      ST_SQR:  cmd.sqr  = 1'b1;
      ST_SUM:  cmd.sum  = 1'b1;
      ST_SQRT: cmd.step = 1'b1;
      ST_DONE: cmd.done = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/hgs_dp.sv */
// ----------------------------------------------------------------------------
// hgs_dp
// Datapath: row stores, raster counters, scaled differences and square root.
// ----------------------------------------------------------------------------
`default_nettype none

module hgs_dp #(
  parameter int MAX_WIDTH = hgs_pkg::HGS_MAX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              restart,
  input  wire logic [11:0]       grid_width,
  input  wire logic [15:0]       grid_depth,
  input  wire logic [23:0]       inv_spacing,
  input  wire hgs_pkg::hgs_in_t  in_data,
  input  wire hgs_pkg::hgs_cmd_t cmd,
  output hgs_pkg::hgs_sts_t      sts,
  output hgs_pkg::hgs_out_t      out_data
);
  import hgs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // Effective geometry
  logic [WW-1:0] eff_w;
  logic [AW-1:0] w_m1;
  logic [15:0]   eff_d, d_m1;

  always_comb begin
    if (grid_width < 12'd2) begin
      eff_w = WW'(2);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    w_m1  = AW'(eff_w - WW'(1));
    eff_d = (grid_depth < 16'd2) ? 16'd2 : grid_depth;
    d_m1  = eff_d - 16'd1;
  end

  // Stream state
  logic [AW-1:0] in_col_r, out_col_r;
  logic [15:0]   in_row_r, out_row_r;
  logic [31:0]   prior0_r, prior1_r;

  // Transaction latches
  logic          cmd_r, drop_r, emit_r, commit_r;
  logic [31:0]   h_r, below_r;
  logic [AW-1:0] ccol_r, xcol_r;
  logic [15:0]   zrow_r;
  logic          xf_r, xl_r, zf_r, zl_r;

  // Decode at accept
  logic          in_full, push_emit, n_nz;
  logic          dec_drop, dec_emit, dec_commit;
  logic [AW-1:0] dec_ccol;

  always_comb begin
    in_full    = (in_row_r >= eff_d);
    push_emit  = (in_row_r >= 16'd2) || ((in_row_r == 16'd1) && (in_col_r != '0));
    n_nz       = (in_row_r != 16'd0) || (in_col_r != '0);
    dec_drop   = (in_data.cmd == CMD_FLUSH) ? !in_full : in_full;
    dec_emit   = (in_data.cmd == CMD_FLUSH) ? 1'b1 : push_emit;
    dec_commit = (in_data.cmd == CMD_FLUSH) ? (out_row_r != d_m1) : n_nz;
    if (in_data.cmd == CMD_FLUSH) begin
      dec_ccol = out_col_r;
    end else begin
      dec_ccol = (in_col_r == '0) ? w_m1 : (in_col_r - AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_data.cmd;
      h_r      <= in_data.height;
      below_r  <= prior0_r;
      drop_r   <= dec_drop;
      emit_r   <= dec_emit;
      commit_r <= dec_commit;
      ccol_r   <= dec_ccol;
      xcol_r   <= out_col_r;
      zrow_r   <= out_row_r;
      xf_r     <= (out_col_r == '0);
      xl_r     <= (out_col_r == w_m1);
      zf_r     <= (out_row_r == 16'd0);
      zl_r     <= (out_row_r == d_m1);
    end
  end

  // Row stores
  logic [AW-1:0] mid_raddr;
  logic [31:0]   mid_rdata, up_rdata;
  logic [31:0]   c_r, up_r, right_r;

  assign mid_raddr = cmd.rd1 ? (xcol_r + AW'(1)) : (emit_r ? xcol_r : ccol_r);

  hgs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.wr && commit_r),
    .waddr (ccol_r),
    .wdata (c_r),
    .raddr (xcol_r),
    .rdata (up_rdata)
  );

  hgs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.wr && commit_r),
    .waddr (ccol_r),
    .wdata (below_r),
    .raddr (mid_raddr),
    .rdata (mid_rdata)
  );

  // Capture neighbors
  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      c_r  <= mid_rdata;
      up_r <= up_rdata;
    end
    if (cmd.wr) begin
      right_r <= mid_rdata;
    end
  end

  // Counters and held samples
  always_ff @(posedge clk) begin
    if (!rst_n || restart || (cmd.done && (cmd_r == CMD_FLUSH) && xl_r && zl_r)) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      prior0_r  <= '0;
      prior1_r  <= '0;
    end else begin
      if (cmd.wr) begin
        if (cmd_r == CMD_PUSH) begin
          prior0_r <= h_r;
          if (in_col_r == w_m1) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 16'd1;
          end else begin
            in_col_r <= in_col_r + AW'(1);
          end
        end
        if (emit_r && !((cmd_r == CMD_FLUSH) && xl_r && zl_r)) begin
          if (out_col_r == w_m1) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 16'd1;
          end else begin
            out_col_r <= out_col_r + AW'(1);
          end
        end
      end
      if (cmd.diff) begin
        prior1_r <= c_r;
      end
    end
  end

  // Differences with edge substitution
  logic signed [32:0] hx, lx, hz, lz, dx, dz;
  logic [32:0]        magx_r, magz_r;
  logic               negx_r, negz_r, k2x_r, k2z_r;

  always_comb begin
    hx = xl_r ? 33'(signed'(c_r)) : 33'(signed'(right_r));
    lx = xf_r ? 33'(signed'(c_r)) : 33'(signed'(prior1_r));
    hz = zl_r ? 33'(signed'(c_r)) : 33'(signed'(below_r));
    lz = zf_r ? 33'(signed'(c_r)) : 33'(signed'(up_r));
    dx = hx - lx;
    dz = hz - lz;
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      negx_r <= dx[32];
      negz_r <= dz[32];
      magx_r <= dx[32] ? 33'(-dx) : 33'(dx);
      magz_r <= dz[32] ? 33'(-dz) : 33'(dz);
      k2x_r  <= !xf_r && !xl_r;
      k2z_r  <= !zf_r && !zl_r;
    end
  end

  // Scale by inverse spacing
  logic [56:0] prodx_r, prodz_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prodx_r <= 57'(magx_r) * 57'(inv_spacing);
      prodz_r <= 57'(magz_r) * 57'(inv_spacing);
    end
  end

  // Round to nearest, ties away from zero, and saturate
  function automatic logic [63:0] round_sat(input logic [56:0] p, input logic k2,
                                            input logic neg);
    logic [56:0] rs;
    logic [40:0] sh;
    logic [31:0] mag;
    rs = p + (k2 ? 57'h10000 : 57'h8000);
    sh = k2 ? {1'b0, rs[56:17]} : rs[56:16];
    if (neg) begin
      mag = (sh > 41'h80000000) ? 32'h80000000 : sh[31:0];
      round_sat = {32'(-mag), mag};
    end else begin
      mag = (sh > 41'h7FFFFFFF) ? 32'h7FFFFFFF : sh[31:0];
      round_sat = {mag, mag};
    end
  endfunction

  logic [63:0] rsx, rsz;
  logic [31:0] gx_r, gz_r, ax_r, az_r;

  assign rsx = round_sat(prodx_r, k2x_r, negx_r);
  assign rsz = round_sat(prodz_r, k2z_r, negz_r);

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      gx_r <= rsx[63:32];
      ax_r <= rsx[31:0];
      gz_r <= rsz[63:32];
      az_r <= rsz[31:0];
    end
  end

  // Squares and sum
  logic [63:0] sqx_r, sqz_r;

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      sqx_r <= 64'(ax_r) * 64'(ax_r);
      sqz_r <= 64'(az_r) * 64'(az_r);
    end
  end

  // Bit-serial square root, two radicand bits per step
  logic [63:0] s_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic [35:0] sh_rem, trial;

  assign sh_rem = {rem_r, s_r[63:62]};
  assign trial  = 36'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      s_r    <= sqx_r + sqz_r;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.step) begin
      s_r   <= {s_r[61:0], 2'b00};
      cnt_r <= cnt_r + 5'd1;
      if (sh_rem >= trial) begin
        rem_r  <= 34'(sh_rem - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= sh_rem[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  // Round the root, saturate and load the result register
  logic [32:0] sl;

  assign sl = 33'(root_r) + 33'(rem_r > 34'(root_r));

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_data.gradient_x   <= gx_r;
      out_data.gradient_z   <= gz_r;
      out_data.slope        <= (sl > 33'h7FFFFFFF) ? 31'h7FFFFFFF : sl[30:0];
      out_data.column       <= 11'(xcol_r);
      out_data.row          <= zrow_r;
      out_data.last_of_grid <= xl_r && zl_r;
    end
  end

  assign sts.drop      = drop_r;
  assign sts.emit      = emit_r;
  assign sts.sqrt_last = (cnt_r == 5'd31);

endmodule

`default_nettype wire

/* hdl/heightfield_gradient_slope.sv */
// ----------------------------------------------------------------------------
// heightfield_gradient_slope
// Streaming central-difference gradient and slope of a raster height grid.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  hgs_in_t  (cmd, height)
//  out_     output     out_valid/out_stall  hgs_out_t (gradients, slope, position)
//  cfg      input      psel/penable/pready  grid_width, grid_depth, inv_spacing
//
//  An ignored transaction ends after the first read state; a sample that yields
//  no result ends after the store write. A transaction with a result also waits
//  out any output stall and runs the bit-serial square root (32 steps).
//  Reset (rst_n, synchronous) clears counters and held samples; the row
//  stores need no clearing. One transaction is in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_gradient_slope #(
  parameter int MAX_WIDTH = hgs_pkg::HGS_MAX_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire hgs_pkg::hgs_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output hgs_pkg::hgs_out_t                   out_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hgs_pkg::HGS_PADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import hgs_pkg::*;

  logic [11:0] grid_width_r;
  logic [15:0] grid_depth_r;
  logic [23:0] inv_spacing_r;
  logic        wr_en, restart;
  hgs_cmd_t    cmd;
  hgs_sts_t    sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && ((paddr[3:2] == REG_GRID_WIDTH) ||
                             (paddr[3:2] == REG_GRID_DEPTH));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_depth_r  <= GRID_DEPTH_RST;
      inv_spacing_r <= INV_SPACING_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[11:0];
        REG_GRID_DEPTH:  grid_depth_r  <= pwdata[15:0];
        REG_INV_SPACING: inv_spacing_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      REG_GRID_WIDTH:  prdata = 32'(grid_width_r);
      REG_GRID_DEPTH:  prdata = 32'(grid_depth_r);
      REG_INV_SPACING: prdata = 32'(inv_spacing_r);
      default:         prdata = '0;
    endcase
  end

  hgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hgs_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .grid_width  (grid_width_r),
    .grid_depth  (grid_depth_r),
    .inv_spacing (inv_spacing_r),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

  // A pending result blocks new input
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // An accepted transaction never shows a result on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid && !in_stall) |=> !out_valid)
    else $error("result appeared too early");

  // A delivered result is not repeated
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

endmodule

`default_nettype wire

/* tb/sv/tb_heightfield_gradient_slope.sv */
// ----------------------------------------------------------------------------
// tb_heightfield_gradient_slope
// Self-checking bench: random and directed height grids pushed through the
// gradient block. A behavioral predictor computes each expected result, and
// the monitor compares every output transaction against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_heightfield_gradient_slope;
  timeunit 1ns;
  timeprecision 1ps;

  import hgs_pkg::*;

  localparam int SETTLE_CYCLES = 64;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  hgs_in_t  in_data;
  hgs_out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [HGS_PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  heightfield_gradient_slope DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  logic [11:0] grid_width_q;
  logic [15:0] grid_depth_q;
  logic [23:0] inv_spacing_q;
  logic signed [31:0] upper_rows [HGS_MAX_WIDTH];
  logic signed [31:0] middle_rows [HGS_MAX_WIDTH];
  int unsigned in_col, in_rw, out_col, out_rw;
  logic signed [31:0] pending_sample, last_center;

  hgs_in_t  sample_queue[$];
  hgs_out_t gradient_queue[$];
  int mismatches;
  int hold_cycles;
  int idle_gap;
  bit in_fire;
  bit stim_done;

  function automatic int unsigned width_eff();
    if (grid_width_q < 2) return 2;
    if (grid_width_q > HGS_MAX_WIDTH) return HGS_MAX_WIDTH;
    return grid_width_q;
  endfunction

  function automatic int unsigned depth_eff();
    return (grid_depth_q < 2) ? 2 : grid_depth_q;
  endfunction

  function automatic void restart_grid();
    in_col = 0; in_rw = 0; out_col = 0; out_rw = 0;
    pending_sample = 0; last_center = 0;
  endfunction

  // Append one transaction to the driver queue
  function automatic void enqueue(hgs_in_t t);
    sample_queue.insert(sample_queue.size(), t);
  endfunction

  // Scale, round half away from zero, saturate
  function automatic logic signed [31:0] scale_diff(longint hi, longint lo, int span);
    longint d;
    logic [63:0] mag, r;
    int k;
    d = hi - lo;
    mag = (d < 0) ? -d : d;
    k = (span == 2) ? 17 : 16;
    r = (mag * inv_spacing_q + (64'd1 << (k - 1))) >> k;
    if (d < 0) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      return -r;
    end
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return r;
  endfunction

  function automatic logic [63:0] round_sqrt(logic [63:0] s);
    logic [63:0] rem, res, b;
    rem = s; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic hgs_out_t gradient_at(int unsigned x, int unsigned z, longint below);
    hgs_out_t r;
    int unsigned w, d, sx, sz;
    longint c, lf, rt, up, dn, ax, az;
    logic [63:0] sl;
    w = width_eff(); d = depth_eff();
    c  = middle_rows[x];
    lf = (x > 0) ? longint'(last_center) : c;
    rt = (x + 1 < w) ? longint'(middle_rows[x + 1]) : c;
    up = (z > 0) ? longint'(upper_rows[x]) : c;
    dn = (z + 1 < d) ? below : c;
    sx = (x > 0) + (x + 1 < w);
    sz = (z > 0) + (z + 1 < d);
    r.gradient_x = scale_diff(rt, lf, sx);
    r.gradient_z = scale_diff(dn, up, sz);
    ax = r.gradient_x; if (ax < 0) ax = -ax;
    az = r.gradient_z; if (az < 0) az = -az;
    sl = round_sqrt(ax * ax + az * az);
    if (sl > 64'h7FFF_FFFF) sl = 64'h7FFF_FFFF;
    r.slope = sl[30:0];
    r.column = x[10:0];
    r.row = z[15:0];
    r.last_of_grid = (x + 1 == w && z + 1 == d);
    last_center = middle_rows[x];
    return r;
  endfunction

  function automatic void commit_row(int unsigned col, logic signed [31:0] v);
    upper_rows[col] = middle_rows[col];
    middle_rows[col] = v;
  endfunction

  function automatic void advance_out_pos(int unsigned w);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_rw++;
    end
  endfunction

  // Predict the result of one accepted transaction
  function automatic void predict_step(hgs_in_t t);
    int unsigned w, d, n, x, z;
    w = width_eff(); d = depth_eff();
    if (t.cmd == CMD_PUSH) begin
      if (in_rw >= d) return;
      n = in_rw * w + in_col;
      if (n >= w + 1) begin
        gradient_queue.insert(gradient_queue.size(),
                              gradient_at(out_col, out_rw, pending_sample));
        advance_out_pos(w);
      end
      if (n > 0) commit_row((in_col == 0) ? w - 1 : in_col - 1, pending_sample);
      pending_sample = t.height;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_rw++;
      end
    end else begin
      if (in_rw < d) return;
      x = out_col; z = out_rw;
      gradient_queue.insert(gradient_queue.size(), gradient_at(x, z, pending_sample));
      if (z + 1 < d) commit_row(x, pending_sample);
      if (x + 1 == w && z + 1 == d) restart_grid();
      else advance_out_pos(w);
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Track input acceptance for the driver
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // Driver: offer queued transactions with random gaps, a few of them long
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_gap <= 0;
    end else if (!in_valid || in_fire) begin
      if (idle_gap > 0) begin
        idle_gap <= idle_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0 &&
                   ($urandom_range(0, 3) != 0 || hold_cycles > 0)) begin
        in_valid <= 1'b1;
        in_data  <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 31) == 0) idle_gap <= $urandom_range(20, 80);
      end
    end
  end

  // Receiver stall: long hold-offs counted here, otherwise mostly short gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: out_stall <= 1'b1;
        3:       out_stall <= ($urandom_range(0, 7) == 0);
        4: begin
          out_stall <= 1'b1;
          if ($urandom_range(0, 15) == 0) hold_cycles <= $urandom_range(20, 60);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_step(in_data);
      if (out_valid && !out_stall) begin
        if (gradient_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          hgs_out_t exp_r;
          exp_r = gradient_queue.pop_front();
          if (exp_r !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (sample_queue.size() > 0 || in_valid || gradient_queue.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GRID_WIDTH: begin
        grid_width_q = v[11:0];
        restart_grid();
      end
      REG_GRID_DEPTH: begin
        grid_depth_q = v[15:0];
        restart_grid();
      end
      REG_INV_SPACING: inv_spacing_q = v[23:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_height(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // Queue a whole grid plus its drain ticks, with some noise
  task automatic queue_grid(int unsigned w, int unsigned d, int mode, bit noisy);
    hgs_in_t t;
    for (int unsigned i = 0; i < w * d; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        t.cmd = CMD_FLUSH; t.height = $urandom();
        enqueue(t);
      end
      t.cmd = CMD_PUSH;
      t.height = rand_height(($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : mode);
      enqueue(t);
    end
    for (int unsigned i = 0; i < w + 1; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        t.cmd = CMD_PUSH; t.height = $urandom();
        enqueue(t);
      end
      t.cmd = CMD_FLUSH; t.height = $urandom();
      enqueue(t);
    end
  endtask

  task automatic set_geometry(logic [31:0] w, logic [31:0] d);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_DEPTH, d);
  endtask

  // Stimulus
  initial begin
    hgs_in_t t;
    int unsigned w, d;
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; hold_cycles = 0; stim_done = 0;
    grid_width_q = GRID_WIDTH_RST;
    grid_depth_q = GRID_DEPTH_RST;
    inv_spacing_q = INV_SPACING_RST;
    restart_grid();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: smallest grid with extreme heights, early flush, late push
    set_geometry(32'd0, 32'd1);
    t.cmd = CMD_FLUSH; t.height = 32'h7FFF_FFFF; enqueue(t);
    t.cmd = CMD_PUSH;
    t.height = 32'h8000_0000; enqueue(t);
    t.height = 32'h7FFF_FFFF; enqueue(t);
    t.height = 32'h7FFF_FFFF; enqueue(t);
    t.height = 32'h8000_0000; enqueue(t);
    t.height = 32'h1234_5678; enqueue(t);
    for (int i = 0; i < 3; i++) begin
      t.cmd = CMD_FLUSH; t.height = 32'hFFFF_FFFF; enqueue(t);
    end
    wait_idle();
    // Largest spacing, then zero spacing, on a 3x3 grid
    write_reg(REG_INV_SPACING, 32'hFFFF_FFFF);
    set_geometry(32'd3, 32'd3);
    queue_grid(3, 3, 0, 0);
    wait_idle();
    write_reg(REG_INV_SPACING, 32'd0);
    queue_grid(3, 3, 0, 0);
    wait_idle();
    // Width of one and depth of zero both act as two
    write_reg(REG_INV_SPACING, 32'd65536);
    set_geometry(32'd1, 32'd0);
    queue_grid(2, 2, 3, 0);
    wait_idle();
    // Abandon a partial grid with a geometry rewrite
    set_geometry(32'd4, 32'd3);
    for (int i = 0; i < 7; i++) begin
      t.cmd = CMD_PUSH; t.height = $urandom(); enqueue(t);
    end
    wait_idle();
    set_geometry(32'd4, 32'd3);
    // Spacing write on an idle block mid-grid takes effect on the next result
    for (int i = 0; i < 6; i++) begin
      t.cmd = CMD_PUSH; t.height = $urandom(); enqueue(t);
    end
    wait_idle();
    write_reg(REG_INV_SPACING, 32'd1);
    queue_grid(4, 2, 0, 0);
    repeat (6) void'(sample_queue.pop_front());
    wait_idle();
    set_geometry(32'd4, 32'd3);
    write_reg(REG_INV_SPACING, 32'hFF_FFFF);
    write_reg(2'd3, 32'hDEAD_BEEF);

    // Random grids; one long hold-off so the block backs up its input
    for (int g = 0; g < 24; g++) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 6);
      d = $urandom_range(2, 5);
      set_geometry(w, d);
      case ($urandom_range(0, 3))
        0: write_reg(REG_INV_SPACING, $urandom_range(1, 32'hFF_FFFF));
        1: write_reg(REG_INV_SPACING, 32'd65536);
        default: ;
      endcase
      queue_grid(w, d, $urandom_range(0, 3), $urandom_range(0, 1));
      if (g == 5) hold_cycles = 3000;
      wait_idle();
    end
    stim_done = 1;
    if (mismatches == 0 && gradient_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(20ns * 3000000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/hgs_pkg.sv
hdl/hgs_ram.sv
hdl/hgs_ctrl.sv
hdl/hgs_dp.sv
hdl/heightfield_gradient_slope.sv
tb/sv/tb_heightfield_gradient_slope.sv
